// ===== rtl/core/pis_pkg.sv =====
// Shared types for the point-in-shape containment test.
// Holds the shape codes and the flag group passed down the pipeline.
// No dependencies.
`default_nettype none

package pis_pkg;

    // Shape kind as carried on the input tuser
    typedef enum logic [1:0] {
        SHAPE_BOX      = 2'd0,
        SHAPE_SPHERE   = 2'd1,
        SHAPE_CYLINDER = 2'd2,
        SHAPE_CAPSULE  = 2'd3
    } t_shape;

    // Per-item decisions made before the squaring stage
    typedef struct packed {
        t_shape shape;
        logic   box_ok;   // all three box half-extent checks pass
        logic   ydim_ok;  // cylinder height check passes
        logic   reject;   // some axis offset exceeds the radius
    } t_flags;

endpackage

`default_nettype wire

// ===== rtl/core/pis_offset.sv =====
// Offset stage: per-axis differences, magnitudes, box and height checks,
// capsule vertical clamp and early radius reject, all registered.
// Depends on pis_pkg.
`default_nettype none

module pis_offset #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_load,
    input  wire pis_pkg::t_shape              i_shape,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_z,
    input  wire logic        [COORD_WIDTH-2:0] i_extent_x,
    input  wire logic        [COORD_WIDTH-2:0] i_extent_y,
    input  wire logic        [COORD_WIDTH-2:0] i_extent_z,
    output pis_pkg::t_flags                   o_flags,
    output logic             [COORD_WIDTH-2:0] o_mag_a,
    output logic             [COORD_WIDTH-2:0] o_mag_b,
    output logic             [COORD_WIDTH-2:0] o_mag_c,
    output logic             [COORD_WIDTH-2:0] o_radius
);
    import pis_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam int E = COORD_WIDTH - 1;

    logic signed [W:0] dx, dy, dz, dy_top, off, vert;
    logic signed [W:0] ey_s;
    logic        [W:0] mag_x, mag_vy, mag_v, mag_z, r_ext;
    logic              box_ok, ydim_ok, reject;

    t_flags            r_flags;
    logic      [E-1:0] r_mag_a, r_mag_b, r_mag_c, r_radius;

    // Differences, one bit wider than the coordinates
    always_comb begin
        dx     = $signed({i_point_x[W-1], i_point_x}) - $signed({i_center_x[W-1], i_center_x});
        dy     = $signed({i_point_y[W-1], i_point_y}) - $signed({i_center_y[W-1], i_center_y});
        dz     = $signed({i_point_z[W-1], i_point_z}) - $signed({i_center_z[W-1], i_center_z});
        ey_s   = $signed({2'b00, i_extent_y});
        dy_top = dy - ey_s;
        r_ext  = {2'b00, i_extent_x};
    end

    // Capsule vertical clamp: below base, above top, or along the segment
    always_comb begin
        if (dy[W]) begin
            off = dy;
        end else if (dy > ey_s) begin
            off = dy_top;
        end else begin
            off = '0;
        end
        case (i_shape)
            SHAPE_CAPSULE:  vert = off;
            SHAPE_CYLINDER: vert = '0;
            default:        vert = dy;
        endcase
    end

    // Magnitudes and checks
    always_comb begin
        mag_x  = dx[W] ? $unsigned(-dx) : $unsigned(dx);
        mag_vy = dy[W] ? $unsigned(-dy) : $unsigned(dy);
        mag_v  = vert[W] ? $unsigned(-vert) : $unsigned(vert);
        mag_z  = dz[W] ? $unsigned(-dz) : $unsigned(dz);
        box_ok = ({mag_x, 1'b0} <= {3'b000, i_extent_x}) &&
                 ({mag_vy, 1'b0} <= {3'b000, i_extent_y}) &&
                 ({mag_z, 1'b0} <= {3'b000, i_extent_z});
        ydim_ok = ({mag_vy, 1'b0} <= {3'b000, i_extent_y});
        reject  = (mag_x > r_ext) || (mag_v > r_ext) || (mag_z > r_ext);
    end

    // Stage register; magnitudes only matter when not rejected
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_flags  <= '{shape: i_shape, box_ok: box_ok, ydim_ok: ydim_ok, reject: reject};
            r_mag_a  <= mag_x[E-1:0];
            r_mag_b  <= mag_v[E-1:0];
            r_mag_c  <= mag_z[E-1:0];
            r_radius <= i_extent_x;
        end
    end

    assign o_flags  = r_flags;
    assign o_mag_a  = r_mag_a;
    assign o_mag_b  = r_mag_b;
    assign o_mag_c  = r_mag_c;
    assign o_radius = r_radius;

endmodule

`default_nettype wire

// ===== rtl/core/pis_square.sv =====
// Squaring stage: four parallel squares (three offsets and the radius),
// registered, with the flag group carried along.
// Depends on pis_pkg.
`default_nettype none

module pis_square #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_load,
    input  wire pis_pkg::t_flags                i_flags,
    input  wire logic     [COORD_WIDTH-2:0]     i_mag_a,
    input  wire logic     [COORD_WIDTH-2:0]     i_mag_b,
    input  wire logic     [COORD_WIDTH-2:0]     i_mag_c,
    input  wire logic     [COORD_WIDTH-2:0]     i_radius,
    output pis_pkg::t_flags                     o_flags,
    output logic          [2*COORD_WIDTH-3:0]   o_sq_a,
    output logic          [2*COORD_WIDTH-3:0]   o_sq_b,
    output logic          [2*COORD_WIDTH-3:0]   o_sq_c,
    output logic          [2*COORD_WIDTH-3:0]   o_sq_r
);
    import pis_pkg::*;

    localparam int E = COORD_WIDTH - 1;

    t_flags          r_flags;
    logic  [2*E-1:0] r_sq_a, r_sq_b, r_sq_c, r_sq_r;

    // One multiplier per operand, result registered
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_flags <= i_flags;
            r_sq_a  <= {{E{1'b0}}, i_mag_a} * {{E{1'b0}}, i_mag_a};
            r_sq_b  <= {{E{1'b0}}, i_mag_b} * {{E{1'b0}}, i_mag_b};
            r_sq_c  <= {{E{1'b0}}, i_mag_c} * {{E{1'b0}}, i_mag_c};
            r_sq_r  <= {{E{1'b0}}, i_radius} * {{E{1'b0}}, i_radius};
        end
    end

    assign o_flags = r_flags;
    assign o_sq_a  = r_sq_a;
    assign o_sq_b  = r_sq_b;
    assign o_sq_c  = r_sq_c;
    assign o_sq_r  = r_sq_r;

endmodule

`default_nettype wire

// ===== rtl/core/pis_compare.sv =====
// Compare stage: sum of squares against the squared radius and the final
// per-shape decision, held in the result register.
// Depends on pis_pkg.
`default_nettype none

module pis_compare #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_load,
    input  wire pis_pkg::t_flags              i_flags,
    input  wire logic     [2*COORD_WIDTH-3:0] i_sq_a,
    input  wire logic     [2*COORD_WIDTH-3:0] i_sq_b,
    input  wire logic     [2*COORD_WIDTH-3:0] i_sq_c,
    input  wire logic     [2*COORD_WIDTH-3:0] i_sq_r,
    output logic                              o_inside
);
    import pis_pkg::*;

    localparam int S = 2 * (COORD_WIDTH - 1);

    logic [S+1:0] sum;
    logic         in_round;
    logic         n_inside;
    logic         r_inside;

    // Sum of squares, two guard bits so it cannot wrap
    always_comb begin
        sum      = {2'b00, i_sq_a} + {2'b00, i_sq_b} + {2'b00, i_sq_c};
        in_round = !i_flags.reject && (sum <= {2'b00, i_sq_r});
        case (i_flags.shape)
            SHAPE_BOX:      n_inside = i_flags.box_ok;
            SHAPE_CYLINDER: n_inside = i_flags.ydim_ok && in_round;
            default:        n_inside = in_round;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_inside <= n_inside;
        end
    end

    assign o_inside = r_inside;

endmodule

`default_nettype wire

// ===== rtl/core/point_in_shape_test.sv =====
// Point containment test for a box, sphere, cylinder or capsule. One
// request is taken per cycle unless all stages are full and the output
// stalls; it passes the input register, offset stage, squaring stage (one
// COORD_WIDTH-1 bit multiplier per operand) and the compare stage that
// holds the result. Each stage moves on when the one after it is empty or
// moving, so bubbles close up and a waiting result does not block intake
// until all four stages are full. Input tuser carries the shape kind;
// the result is bit 0 of the output tdata.
// Depends on pis_pkg, pis_offset, pis_square, pis_compare.
`default_nettype none

module point_in_shape_test #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      s_axis_tvalid,
    output logic                                           s_axis_tready,
    // point_x, point_y, point_z, center_x, center_y, center_z,
    // extent_x, extent_y, extent_z, zero fill
    input  wire logic [((9*COORD_WIDTH-3+7)/8)*8-1:0]      s_axis_tdata,
    // shape
    input  wire logic [1:0]                                s_axis_tuser,
    output logic                                           m_axis_tvalid,
    input  wire logic                                      m_axis_tready,
    // inside_res, zero fill
    output logic [7:0]                                     m_axis_tdata
);
    import pis_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam int E = COORD_WIDTH - 1;

    // Field offsets in the input tdata
    localparam int PX = 0;
    localparam int PY = W;
    localparam int PZ = 2 * W;
    localparam int CX = 3 * W;
    localparam int CY = 4 * W;
    localparam int CZ = 5 * W;
    localparam int EX = 6 * W;
    localparam int EY = 6 * W + E;
    localparam int EZ = 6 * W + 2 * E;

    // Stage valids and ready chain
    logic r_v0, r_v1, r_v2, r_v3;
    logic rdy0, rdy1, rdy2, rdy3;

    // Input register
    t_shape          r_shape;
    logic signed [W-1:0] r_px, r_py, r_pz, r_cx, r_cy, r_cz;
    logic        [E-1:0] r_ex, r_ey, r_ez;

    t_flags          flags1, flags2;
    logic  [E-1:0]   mag_a, mag_b, mag_c, radius;
    logic  [2*E-1:0] sq_a, sq_b, sq_c, sq_r;
    logic            res_inside;

    always_comb begin
        rdy3 = !r_v3 || m_axis_tready;
        rdy2 = !r_v2 || rdy3;
        rdy1 = !r_v1 || rdy2;
        rdy0 = !r_v0 || rdy1;
    end

    assign s_axis_tready = rdy0;

    // Stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy0) r_v0 <= s_axis_tvalid;
            if (rdy1) r_v1 <= r_v0;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (rdy0 && s_axis_tvalid) begin
            r_shape <= t_shape'(s_axis_tuser);
            r_px    <= s_axis_tdata[PX +: W];
            r_py    <= s_axis_tdata[PY +: W];
            r_pz    <= s_axis_tdata[PZ +: W];
            r_cx    <= s_axis_tdata[CX +: W];
            r_cy    <= s_axis_tdata[CY +: W];
            r_cz    <= s_axis_tdata[CZ +: W];
            r_ex    <= s_axis_tdata[EX +: E];
            r_ey    <= s_axis_tdata[EY +: E];
            r_ez    <= s_axis_tdata[EZ +: E];
        end
    end

    pis_offset #(.COORD_WIDTH(COORD_WIDTH)) u_offset (
        .i_clk      (i_clk),
        .i_load     (rdy1 && r_v0),
        .i_shape    (r_shape),
        .i_point_x  (r_px),
        .i_point_y  (r_py),
        .i_point_z  (r_pz),
        .i_center_x (r_cx),
        .i_center_y (r_cy),
        .i_center_z (r_cz),
        .i_extent_x (r_ex),
        .i_extent_y (r_ey),
        .i_extent_z (r_ez),
        .o_flags    (flags1),
        .o_mag_a    (mag_a),
        .o_mag_b    (mag_b),
        .o_mag_c    (mag_c),
        .o_radius   (radius)
    );

    pis_square #(.COORD_WIDTH(COORD_WIDTH)) u_square (
        .i_clk    (i_clk),
        .i_load   (rdy2 && r_v1),
        .i_flags  (flags1),
        .i_mag_a  (mag_a),
        .i_mag_b  (mag_b),
        .i_mag_c  (mag_c),
        .i_radius (radius),
        .o_flags  (flags2),
        .o_sq_a   (sq_a),
        .o_sq_b   (sq_b),
        .o_sq_c   (sq_c),
        .o_sq_r   (sq_r)
    );

    pis_compare #(.COORD_WIDTH(COORD_WIDTH)) u_compare (
        .i_clk    (i_clk),
        .i_load   (rdy3 && r_v2),
        .i_flags  (flags2),
        .i_sq_a   (sq_a),
        .i_sq_b   (sq_b),
        .i_sq_c   (sq_c),
        .i_sq_r   (sq_r),
        .o_inside (res_inside)
    );

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {7'b0000000, res_inside};

    // A held stage keeps its item while the next one is blocked
    a_hold_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !rdy2 |=> r_v1)
        else $error("offset stage dropped a blocked item");

    // An item in the square stage moves into the result stage when it is free
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && rdy3 |=> r_v3)
        else $error("item lost between square and compare stages");

    // Intake stalls only when every stage is occupied
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_v0 && r_v1 && r_v2 && r_v3)
        else $error("intake stalled with an empty stage");

endmodule

`default_nettype wire

// ===== tb/tb_point_in_shape_test.sv =====
// Self-checking bench for point_in_shape_test: box, sphere, cylinder and capsule queries
// are checked against an integer containment predictor, with random stalls on both streams.
// Depends on pis_pkg and the point_in_shape_test RTL.
module tb_point_in_shape_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pis_pkg::*;

    localparam int CW         = 16;
    localparam int TDATA_W    = ((9*CW-3+7)/8)*8;
    localparam int NUM_RANDOM = 1730;
    localparam int CALM_FROM  = 700;
    localparam int CALM_TO    = 1000;
    localparam int HOLD_AFTER = 40;
    localparam int HOLD_LEN   = 150;
    localparam int DRAIN_WAIT = 20;
    localparam int CYCLE_LIMIT = 200000;

    // One containment query as seen on the input stream
    typedef struct {
        t_shape               shape;
        logic signed [CW-1:0] px, py, pz;
        logic signed [CW-1:0] cx, cy, cz;
        logic [CW-2:0]        ex, ey, ez;
    } t_query;

    // Tracks expected inside/outside answers in request order
    class inside_scoreboard;
        bit expected_inside[$];
        int errors;

        static function longint magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // a^2 + b^2 + c^2 <= r^2, rejecting large offsets before squaring
        static function bit in_radius(longint a, longint b, longint c, longint r);
            longint ua, ub, uc;
            ua = magnitude(a);
            ub = magnitude(b);
            uc = magnitude(c);
            if (ua > r || ub > r || uc > r)
                return 1'b0;
            return (ua*ua + ub*ub + uc*uc) <= r*r;
        endfunction

        static function bit predict_inside(t_query q);
            longint dx, dy, dz, ex, ey, ez, yoff;
            bit     hit;
            dx = longint'(q.px) - longint'(q.cx);
            dy = longint'(q.py) - longint'(q.cy);
            dz = longint'(q.pz) - longint'(q.cz);
            ex = longint'(q.ex);
            ey = longint'(q.ey);
            ez = longint'(q.ez);
            case (q.shape)
                SHAPE_BOX: begin
                    hit = magnitude(dx)*2 <= ex && magnitude(dy)*2 <= ey &&
                          magnitude(dz)*2 <= ez;
                end
                SHAPE_SPHERE: begin
                    hit = in_radius(dx, dy, dz, ex);
                end
                SHAPE_CYLINDER: begin
                    hit = magnitude(dy)*2 <= ey && in_radius(dx, 0, dz, ex);
                end
                default: begin
                    // vertical distance to the capsule segment
                    if (dy < 0)
                        yoff = dy;
                    else if (dy > ey)
                        yoff = dy - ey;
                    else
                        yoff = 0;
                    hit = in_radius(dx, yoff, dz, ex);
                end
            endcase
            return hit;
        endfunction

        function void note_query(t_query q);
            expected_inside.push_back(predict_inside(q));
        endfunction

        function void check_answer(bit inside_res);
            bit want;
            if (expected_inside.size() == 0) begin
                $error("inside_res: result with no request pending, got %0d", inside_res);
                errors++;
                return;
            end
            want = expected_inside.pop_front();
            if (want !== inside_res) begin
                $error("inside_res: expected %0d, got %0d", want, inside_res);
                errors++;
            end
        endfunction

        function int pending();
            return expected_inside.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;
    logic [1:0]         s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [7:0]         m_axis_tdata;

    inside_scoreboard board;
    int               queries_sent;
    int               cycles;
    bit               calm;

    point_in_shape_test #(
        .COORD_WIDTH (CW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result monitor: values read here are the ones present before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_answer(m_axis_tdata[0]);
    end

    function automatic t_query mk(t_shape s, int px, int py, int pz, int cx, int cy,
                                  int cz, int ex, int ey, int ez);
        t_query q;
        q.shape = s;
        q.px = px[CW-1:0];
        q.py = py[CW-1:0];
        q.pz = pz[CW-1:0];
        q.cx = cx[CW-1:0];
        q.cy = cy[CW-1:0];
        q.cz = cz[CW-1:0];
        q.ex = ex[CW-2:0];
        q.ey = ey[CW-2:0];
        q.ez = ez[CW-2:0];
        return q;
    endfunction

    // Offset in [-(e+2), e+2]
    function automatic int near_offset(int e);
        return int'($urandom_range(0, 2*e + 4)) - (e + 2);
    endfunction

    function automatic t_query random_query();
        t_query q;
        int     scale, cx, cy, cz, ex, ey, ez, dx, dy, dz;
        q.shape = t_shape'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) begin
            // fully random fields
            q.px = CW'($urandom);
            q.py = CW'($urandom);
            q.pz = CW'($urandom);
            q.cx = CW'($urandom);
            q.cy = CW'($urandom);
            q.cz = CW'($urandom);
            q.ex = (CW-1)'($urandom);
            q.ey = (CW-1)'($urandom);
            q.ez = (CW-1)'($urandom);
            return q;
        end
        // point placed near the shape boundary
        case ($urandom_range(0, 3))
            0: scale = 15;
            1: scale = 255;
            2: scale = 4095;
            default: scale = 32767;
        endcase
        ex = $urandom_range(0, scale);
        ey = $urandom_range(0, scale);
        ez = $urandom_range(0, scale);
        cx = int'($urandom_range(0, 65535)) - 32768;
        cy = int'($urandom_range(0, 65535)) - 32768;
        cz = int'($urandom_range(0, 65535)) - 32768;
        case (q.shape)
            SHAPE_BOX: begin
                dx = near_offset(ex/2);
                dy = near_offset(ey/2);
                dz = near_offset(ez/2);
            end
            SHAPE_CYLINDER: begin
                dx = near_offset(ex);
                dy = near_offset(ey/2);
                dz = near_offset(ex);
            end
            SHAPE_SPHERE: begin
                dx = near_offset(ex);
                dy = near_offset(ex);
                dz = near_offset(ex);
            end
            default: begin
                dx = near_offset(ex);
                dy = int'($urandom_range(0, ey + 2*ex + 4)) - (ex + 2);
                dz = near_offset(ex);
            end
        endcase
        return mk(q.shape, cx + dx, cy + dy, cz + dz, cx, cy, cz, ex, ey, ez);
    endfunction

    // Offer one request and wait for it to be taken; returns at a falling edge
    task automatic send_query(input t_query q);
        s_axis_tdata  <= {{(TDATA_W-9*CW+3){1'b0}}, q.ez, q.ey, q.ex,
                          q.cz, q.cy, q.cx, q.pz, q.py, q.px};
        s_axis_tuser  <= q.shape;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        board.note_query(q);
        queries_sent++;
        @(negedge i_clk);
    endtask

    // Random sender gap, entered and left at a falling edge
    task automatic sender_gap();
        if (!calm && $urandom_range(0, 99) < 32) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    // Receiver: one long hold-off early on, then random stalls
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        while (queries_sent < HOLD_AFTER) begin
            m_axis_tready <= 1'b1;
            @(negedge i_clk);
        end
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge i_clk);
        forever begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 32);
            @(negedge i_clk);
        end
    end

    // Stimulus and end of run
    initial begin
        t_query directed[$];
        board         = new();
        queries_sent  = 0;
        calm          = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = SHAPE_BOX;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // box: inclusive edges, zero size, coordinate extremes
        directed.push_back(mk(SHAPE_BOX, 5, 10, 15, 0, 0, 0, 10, 20, 30));
        directed.push_back(mk(SHAPE_BOX, 6, 10, 15, 0, 0, 0, 10, 20, 30));
        directed.push_back(mk(SHAPE_BOX, 7, -9, 3, 7, -9, 3, 0, 0, 0));
        directed.push_back(mk(SHAPE_BOX, 7, -8, 3, 7, -9, 3, 0, 0, 0));
        directed.push_back(mk(SHAPE_BOX, -32768, -32768, -32768, 32767, 32767, 32767,
                              32767, 32767, 32767));
        directed.push_back(mk(SHAPE_BOX, 32767, 0, 0, -32768, 0, 0, 32767, 32767, 32767));
        directed.push_back(mk(SHAPE_BOX, -32768, -32768, -32768, -32768, -32768, -32768,
                              0, 0, 0));
        // sphere: on the surface, just outside, zero radius, full range
        directed.push_back(mk(SHAPE_SPHERE, 3, 4, 0, 0, 0, 0, 5, 0, 0));
        directed.push_back(mk(SHAPE_SPHERE, 3, 4, 1, 0, 0, 0, 5, 0, 0));
        directed.push_back(mk(SHAPE_SPHERE, 100, 100, 100, 100, 100, 100, 0, 32767, 32767));
        directed.push_back(mk(SHAPE_SPHERE, 32767, 0, 0, 0, 0, 0, 32767, 0, 0));
        directed.push_back(mk(SHAPE_SPHERE, -32768, 0, 0, 0, 0, 0, 32767, 0, 0));
        directed.push_back(mk(SHAPE_SPHERE, 20000, 20000, 20000, 0, 0, 0, 32767, 0, 0));
        // cylinder: height edge, just above, zero size
        directed.push_back(mk(SHAPE_CYLINDER, 3, 5, 4, 0, 0, 0, 5, 10, 0));
        directed.push_back(mk(SHAPE_CYLINDER, 3, 6, 4, 0, 0, 0, 5, 10, 0));
        directed.push_back(mk(SHAPE_CYLINDER, -5, 9, 2, -5, 9, 2, 0, 0, 0));
        // capsule: below the base, around the top, the middle, zero length, far away
        directed.push_back(mk(SHAPE_CAPSULE, 4, -3, 0, 0, 0, 0, 5, 100, 0));
        directed.push_back(mk(SHAPE_CAPSULE, 4, 103, 0, 0, 0, 0, 5, 100, 0));
        directed.push_back(mk(SHAPE_CAPSULE, 4, 104, 0, 0, 0, 0, 5, 100, 0));
        directed.push_back(mk(SHAPE_CAPSULE, 5, 50, 0, 0, 0, 0, 5, 100, 0));
        directed.push_back(mk(SHAPE_CAPSULE, 6, 50, 0, 0, 0, 0, 5, 100, 0));
        directed.push_back(mk(SHAPE_CAPSULE, 4, 3, 0, 0, 0, 0, 5, 0, 0));
        directed.push_back(mk(SHAPE_CAPSULE, 0, 32767, 0, 0, -32768, 0, 32767, 32767, 0));
        directed.push_back(mk(SHAPE_CAPSULE, -32768, 0, 32767, 32767, 0, -32768,
                              32767, 32767, 32767));

        foreach (directed[i])
            send_query(directed[i]);

        // random requests, with a stretch where neither side stalls
        for (int n = 0; n < NUM_RANDOM; n++) begin
            calm = (queries_sent >= CALM_FROM && queries_sent < CALM_TO);
            sender_gap();
            send_query(random_query());
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        // drain, then watch for stray results
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
